@@ sv/mvt_pkg.sv @@
// mvt_pkg: shared widths, defaults and stage-enable struct for the
// matrix-vector transform unit. No dependencies.
`default_nettype none

package mvt_pkg;

  // fixed data widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DIM    = 4;

  // default fraction width of the fixed-point format
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // action codes
  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_TRANSFORM = 1'b1;

  // pipeline register enables handed to the lanes
  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } stage_en_t;

endpackage

`default_nettype wire

@@ sv/matrix_vector_transform_unit.sv @@
// matrix_vector_transform_unit: 4x4 Q-format matrix times vec4, four
// parallel row lanes and a saturating merge stage. Depends on mvt_pkg,
// mvt_lane and mvt_merge.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_stall  | action, entry_index, entry_value, vec_x..w
//   output  | out_valid / out_stall| out_x, out_y, out_z, out_w, overflow
//
// One transaction per cycle sustained while the output is not stalled; a
// transform passes the product register (loaded at acceptance), then the sum
// register, then the output register.
// A load writes the matrix at acceptance and gives no result.
// Reset restores the identity matrix and empties the pipeline.
// Stages with a bubble keep moving while the output is stalled; in_stall rises
// only when every stage holds a transaction and the output is stalled.
`default_nettype none

module matrix_vector_transform_unit #(
  parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              action,
  input  wire logic [3:0]                        entry_index,
  input  wire logic signed [mvt_pkg::DATA_W-1:0] entry_value,
  input  wire logic signed [mvt_pkg::DATA_W-1:0] vec_x,
  input  wire logic signed [mvt_pkg::DATA_W-1:0] vec_y,
  input  wire logic signed [mvt_pkg::DATA_W-1:0] vec_z,
  input  wire logic signed [mvt_pkg::DATA_W-1:0] vec_w,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [mvt_pkg::DATA_W-1:0]      out_x,
  output logic signed [mvt_pkg::DATA_W-1:0]      out_y,
  output logic signed [mvt_pkg::DATA_W-1:0]      out_z,
  output logic signed [mvt_pkg::DATA_W-1:0]      out_w,
  output logic                                   overflow
);

  localparam logic [mvt_pkg::DATA_W-1:0] ONE = mvt_pkg::DATA_W'(1) << FRAC_BITS;

  logic [mvt_pkg::DIM-1:0][mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] mat;
  logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] vec;
  logic [mvt_pkg::DIM-1:0][mvt_pkg::SUM_W-1:0]  sums;
  logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] lanes;
  mvt_pkg::stage_en_t                            en;
  logic in_accept, prod_valid, sum_valid, out_en;

  // pipeline flow control
  assign out_en     = !out_valid || !out_stall;
  assign en.sum_en  = !sum_valid || out_en;
  assign en.prod_en = !prod_valid || en.sum_en;
  assign in_stall   = !en.prod_en;
  assign in_accept  = in_valid && !in_stall;

  assign vec = {vec_w, vec_z, vec_y, vec_x};

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        for (int c = 0; c < mvt_pkg::DIM; c++) begin
          mat[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (in_accept && action == mvt_pkg::ACT_LOAD) begin
      mat[entry_index[3:2]][entry_index[1:0]] <= entry_value;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (en.prod_en) prod_valid <= in_accept && action == mvt_pkg::ACT_TRANSFORM;
      if (en.sum_en)  sum_valid  <= prod_valid;
      if (out_en)     out_valid  <= sum_valid;
    end
  end

  // row lanes
  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_lane
    mvt_lane u_lane (
      .clk  (clk),
      .en   (en),
      .coef (mat[r]),
      .vec  (vec),
      .sum  (sums[r])
    );
  end

  // saturating merge and output register
  mvt_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk      (clk),
    .load     (out_en),
    .sums     (sums),
    .lanes    (lanes),
    .overflow (overflow)
  );

  assign out_x = lanes[0];
  assign out_y = lanes[1];
  assign out_z = lanes[2];
  assign out_w = lanes[3];

  // stall only when the first stage is occupied
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> prod_valid)
    else $error("input stalled with empty product stage");

  // an accepted transform always lands in the product stage
  a_transform_enters: assert property (@(posedge clk) disable iff (rst)
    in_accept && action == mvt_pkg::ACT_TRANSFORM |=> prod_valid)
    else $error("accepted transform lost");

  // a finished sum reaches the output when the output moves
  a_sum_to_out: assert property (@(posedge clk) disable iff (rst)
    sum_valid && out_en |=> out_valid)
    else $error("sum stage result lost");

  // overflow means some lane sits at a saturation limit
  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      (out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
       out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
       out_z == 32'sh7fffffff || out_z == 32'sh80000000 ||
       out_w == 32'sh7fffffff || out_w == 32'sh80000000))
    else $error("overflow without saturated lane");

endmodule

`default_nettype wire

@@ sv/mvt_lane.sv @@
// mvt_lane: one matrix row, four exact products then their exact sum.
// Depends on mvt_pkg.
`default_nettype none

module mvt_lane (
  input  wire logic                                        clk,
  input  wire mvt_pkg::stage_en_t                          en,
  input  wire logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] coef,
  input  wire logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] vec,
  output logic signed [mvt_pkg::SUM_W-1:0]                 sum
);

  logic signed [mvt_pkg::PROD_W-1:0] prod [mvt_pkg::DIM];

  // products of the stored matrix row and the incoming vector
  always_ff @(posedge clk) begin
    if (en.prod_en) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod[c] <= $signed(coef[c]) * $signed(vec[c]);
      end
    end
  end

  // exact sum of the four products
  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      sum <= mvt_pkg::SUM_W'(prod[0]) + mvt_pkg::SUM_W'(prod[1])
           + mvt_pkg::SUM_W'(prod[2]) + mvt_pkg::SUM_W'(prod[3]);
    end
  end

endmodule

`default_nettype wire

@@ sv/mvt_merge.sv @@
// mvt_merge: scales each lane sum, saturates to 32 bits, merges the
// overflow flags and holds the output register. Depends on mvt_pkg.
`default_nettype none

module mvt_merge #(
  parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                          clk,
  input  wire logic                                          load,
  input  wire logic [mvt_pkg::DIM-1:0][mvt_pkg::SUM_W-1:0]   sums,
  output logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0]       lanes,
  output logic                                               overflow
);

  localparam logic signed [mvt_pkg::SUM_W-1:0] LANE_MAX =
    mvt_pkg::SUM_W'(signed'(2147483647));
  localparam logic signed [mvt_pkg::SUM_W-1:0] LANE_MIN =
    -(mvt_pkg::SUM_W'(signed'(64'sd2147483648)));

  logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] sat;
  logic [mvt_pkg::DIM-1:0]                      ovf;

  // floor shift and clamp per lane
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      logic signed [mvt_pkg::SUM_W-1:0] scaled;
      scaled = $signed(sums[r]) >>> FRAC_BITS;
      if (scaled > LANE_MAX) begin
        sat[r] = LANE_MAX[mvt_pkg::DATA_W-1:0];
        ovf[r] = 1'b1;
      end else if (scaled < LANE_MIN) begin
        sat[r] = LANE_MIN[mvt_pkg::DATA_W-1:0];
        ovf[r] = 1'b1;
      end else begin
        sat[r] = scaled[mvt_pkg::DATA_W-1:0];
        ovf[r] = 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      lanes    <= sat;
      overflow <= |ovf;
    end
  end

endmodule

`default_nettype wire
